// File: hdl/aba_pkg.sv
// ============================================================================
// aba_pkg: shared definitions for the arena block allocator
// Widths, register indexes, result codes, controller states and the
// command/status bundles that join the controller and the datapath.
// ============================================================================
package aba_pkg;

    localparam int MAX_BLOCKS = 16;
    localparam int SLOT_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

    localparam int REQ_W      = 16;
    localparam int ALIGN_W    = 13;
    localparam int SIZE_W     = 17;
    localparam int TOTAL_W    = 21;
    localparam int BLOCK_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int DIV_CNT_W  = $clog2(REQ_W + 1);
    localparam int MEM_W      = 2 * SIZE_W;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_ALIGN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST    = 2'd2;

    localparam logic [ALIGN_W-1:0] ALIGN_RESET   = 13'd8;
    localparam logic [SIZE_W-1:0]  DEFAULT_RESET = 17'd4096;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED = 2'd0,
        ST_REFUSED = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_CLEARED = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_ROUND,
        S_DECIDE,
        S_CUR_CHK,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_OPEN,
        S_GRANT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;        // load the request and arm the divider
        logic div_step;
        logic round;        // register the rounded size
        logic clear;
        logic rd_en;
        logic rd_sel_k;     // read the search slot instead of the current slot
        logic k_init;
        logic k_dec;
        logic grant;
        logic open_blk;
        logic set_empty;
        logic set_refused;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic cur_valid;
        logic need_zero;
        logic room;
        logic k_zero;
        logic open_empty;
        logic full;
        logic fast;
    } t_dp_sts;

endpackage

// File: hdl/aba_req_if.sv
// ============================================================================
// aba_req_if: request channel
// Valid/ready channel that carries one allocate or release request.
// ============================================================================
interface aba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic [aba_pkg::REQ_W-1:0] request_bytes;

    modport source (output valid, output func, output request_bytes, input ready);
    modport sink   (input valid, input func, input request_bytes, output ready);
endinterface

// File: hdl/aba_res_if.sv
// ============================================================================
// aba_res_if: result channel
// Valid/ready channel that carries one allocation result.
// ============================================================================
interface aba_res_if;
    logic                         valid;
    logic                         ready;
    logic [aba_pkg::STATUS_W-1:0] status;
    logic [aba_pkg::BLOCK_W-1:0]  grant_block;
    logic [aba_pkg::SIZE_W-1:0]   grant_offset;
    logic [aba_pkg::TOTAL_W-1:0]  total_bytes;

    modport source (output valid, output status, output grant_block, output grant_offset,
                    output total_bytes, input ready);
    modport sink   (input valid, input status, input grant_block, input grant_offset,
                    input total_bytes, output ready);
endinterface

// File: hdl/aba_ctrl.sv
// ============================================================================
// aba_ctrl: allocator controller
// Sequences divide, rounding, current block check, newest-first search,
// block opening and the result transfer.
// ============================================================================
module aba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  logic             i_req_func,
    output logic             o_req_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    input  aba_pkg::t_dp_sts i_sts,
    output aba_pkg::t_dp_cmd o_cmd
);
    import aba_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_search_go;
    logic   w_out_free;

    assign w_accept    = i_req_valid && (r_state == S_IDLE);
    assign w_search_go = !i_sts.fast && !i_sts.open_empty;
    assign w_out_free  = !r_out_valid || i_res_ready;

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_req_func == FUNC_CLEAR) ? S_FINISH : S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.cur_valid) begin
                    n_state = S_CUR_CHK;
                end else if (i_sts.need_zero) begin
                    n_state = S_FINISH;
                end else begin
                    n_state = w_search_go ? S_SRCH_RD : S_OPEN;
                end
            end
            S_CUR_CHK: begin
                if (i_sts.room) begin
                    n_state = S_GRANT;
                end else begin
                    n_state = w_search_go ? S_SRCH_RD : S_OPEN;
                end
            end
            S_SRCH_RD: begin
                n_state = S_SRCH_CHK;
            end
            S_SRCH_CHK: begin
                if (i_sts.room) begin
                    n_state = S_GRANT;
                end else if (i_sts.k_zero) begin
                    n_state = S_OPEN;
                end else begin
                    n_state = S_SRCH_RD;
                end
            end
            S_OPEN: begin
                n_state = S_FINISH;
            end
            S_GRANT: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Commands and output valid.
    always_comb begin
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_res_ready;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.clear = (i_req_func == FUNC_CLEAR);
                    o_cmd.start = (i_req_func == FUNC_ALLOC);
                end
            end
            S_DIV: begin
                o_cmd.div_step = !i_sts.div_done;
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
            end
            S_DECIDE: begin
                if (i_sts.cur_valid) begin
                    o_cmd.rd_en = 1'b1;
                end else if (i_sts.need_zero) begin
                    o_cmd.set_empty = 1'b1;
                end else begin
                    o_cmd.k_init = w_search_go;
                end
            end
            S_CUR_CHK: begin
                o_cmd.k_init = !i_sts.room && w_search_go;
            end
            S_SRCH_RD: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel_k = 1'b1;
            end
            S_SRCH_CHK: begin
                o_cmd.k_dec = !i_sts.room && !i_sts.k_zero;
            end
            S_OPEN: begin
                o_cmd.open_blk    = !i_sts.full;
                o_cmd.set_refused = i_sts.full;
            end
            S_GRANT: begin
                o_cmd.grant = 1'b1;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                end
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/aba_dp.sv
// ============================================================================
// aba_dp: allocator datapath
// Configuration registers, bit-serial remainder unit, block table memory,
// allocator state and the result registers.
// ============================================================================
module aba_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  aba_pkg::t_dp_cmd                  i_cmd,
    output aba_pkg::t_dp_sts                  o_sts,
    input  logic                              i_cfg_we,
    input  logic [aba_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [aba_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [aba_pkg::REQ_W-1:0]         i_req_bytes,
    output logic [aba_pkg::STATUS_W-1:0]      o_status,
    output logic [aba_pkg::BLOCK_W-1:0]       o_grant_block,
    output logic [aba_pkg::SIZE_W-1:0]        o_grant_offset,
    output logic [aba_pkg::TOTAL_W-1:0]       o_total_bytes
);
    import aba_pkg::*;

    // Configuration and allocator state.
    logic [ALIGN_W-1:0]   r_align;
    logic [SIZE_W-1:0]    r_default;
    logic                 r_fast;
    logic [CNT_W-1:0]     r_open;
    logic [SLOT_W-1:0]    r_cur_slot;
    logic                 r_cur_valid;
    logic [TOTAL_W-1:0]   r_total;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    // Working registers.
    logic [REQ_W-1:0]     r_req;
    logic [REQ_W-1:0]     r_div_sh;
    logic [ALIGN_W-1:0]   r_rem;
    logic [SIZE_W-1:0]    r_need;
    logic [SLOT_W-1:0]    r_k;
    logic [SLOT_W-1:0]    r_rd_addr;
    logic [MEM_W-1:0]     r_rd_data;
    t_status              r_res_status;
    logic [SLOT_W-1:0]    r_res_block;
    logic [SIZE_W-1:0]    r_res_offset;
    t_status              r_out_status;
    logic [SLOT_W-1:0]    r_out_block;
    logic [SIZE_W-1:0]    r_out_offset;
    logic [TOTAL_W-1:0]   r_out_total;

    // Block table: capacity in the upper half, fill in the lower half.
    logic [MEM_W-1:0]     r_mem [MAX_BLOCKS];

    logic [ALIGN_W-1:0]   w_gran;
    logic [ALIGN_W:0]     w_trial;
    logic                 w_ge;
    logic [ALIGN_W-1:0]   w_rem_next;
    logic [SIZE_W-1:0]    w_need;
    logic [SIZE_W-1:0]    w_cap;
    logic [SIZE_W-1:0]    w_fill;
    logic [SIZE_W:0]      w_fill_sum;
    logic                 w_room;
    logic [SIZE_W-1:0]    w_size;
    logic [TOTAL_W:0]     w_total_sum;
    logic [TOTAL_W-1:0]   w_total_sat;
    logic [SLOT_W-1:0]    w_rd_addr;
    logic [SLOT_W-1:0]    w_open_slot;
    logic [CNT_W-1:0]     w_open_m1;
    logic                 w_full;
    logic                 w_mem_we;
    logic [SLOT_W-1:0]    w_mem_addr;
    logic [MEM_W-1:0]     w_mem_wdata;

    // A zero granule behaves as one.
    assign w_gran     = (r_align == '0) ? ALIGN_W'(1) : r_align;

    // One quotient bit per cycle; only the remainder is kept.
    assign w_trial    = {r_rem, r_div_sh[REQ_W-1]};
    assign w_ge       = (w_trial >= {1'b0, w_gran});
    assign w_rem_next = w_ge ? ALIGN_W'(w_trial - {1'b0, w_gran}) : w_trial[ALIGN_W-1:0];

    assign w_need     = (r_rem != '0)
                      ? SIZE_W'(r_req) + SIZE_W'(w_gran) - SIZE_W'(r_rem)
                      : SIZE_W'(r_req);

    assign w_cap      = r_rd_data[MEM_W-1:SIZE_W];
    assign w_fill     = r_rd_data[SIZE_W-1:0];
    assign w_fill_sum = {1'b0, w_fill} + {1'b0, r_need};
    assign w_room     = (w_fill_sum <= {1'b0, w_cap});

    assign w_size      = (r_need > r_default) ? r_need : r_default;
    assign w_total_sum = {1'b0, r_total} + (TOTAL_W + 1)'(w_size);
    assign w_total_sat = w_total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : w_total_sum[TOTAL_W-1:0];

    assign w_rd_addr   = i_cmd.rd_sel_k ? r_k : r_cur_slot;
    assign w_open_slot = r_open[SLOT_W-1:0];
    assign w_open_m1   = r_open - CNT_W'(1);
    assign w_full      = (r_open == CNT_W'(MAX_BLOCKS));

    assign w_mem_we    = i_cmd.open_blk || i_cmd.grant;
    assign w_mem_addr  = i_cmd.grant ? r_rd_addr : w_open_slot;
    assign w_mem_wdata = i_cmd.grant ? {w_cap, w_fill_sum[SIZE_W-1:0]} : {w_size, r_need};

    assign o_sts.div_done   = (r_div_cnt == '0);
    assign o_sts.cur_valid  = r_cur_valid;
    assign o_sts.need_zero  = (r_need == '0);
    assign o_sts.room       = w_room;
    assign o_sts.k_zero     = (r_k == '0);
    assign o_sts.open_empty = (r_open == '0);
    assign o_sts.full       = w_full;
    assign o_sts.fast       = r_fast;

    assign o_status       = r_out_status;
    assign o_grant_block  = BLOCK_W'(r_out_block);
    assign o_grant_offset = r_out_offset;
    assign o_total_bytes  = r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align     <= ALIGN_RESET;
            r_default   <= DEFAULT_RESET;
            r_fast      <= 1'b0;
            r_open      <= '0;
            r_cur_slot  <= '0;
            r_cur_valid <= 1'b0;
            r_total     <= '0;
            r_div_cnt   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ALIGN:   r_align   <= i_cfg_data[ALIGN_W-1:0];
                    REG_DEFAULT: r_default <= i_cfg_data[SIZE_W-1:0];
                    REG_FAST:    r_fast    <= i_cfg_data[0];
                    default:     ;
                endcase
            end
            if (i_cmd.start) begin
                r_div_cnt <= DIV_CNT_W'(REQ_W);
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
            end
            if (i_cmd.clear) begin
                r_open      <= '0;
                r_cur_slot  <= '0;
                r_cur_valid <= 1'b0;
                r_total     <= '0;
            end else if (i_cmd.open_blk) begin
                r_open      <= r_open + CNT_W'(1);
                r_cur_slot  <= w_open_slot;
                r_cur_valid <= 1'b1;
                r_total     <= w_total_sat;
            end else if (i_cmd.grant) begin
                r_cur_slot  <= r_rd_addr;
                r_cur_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_req    <= i_req_bytes;
            r_div_sh <= i_req_bytes;
            r_rem    <= '0;
        end else if (i_cmd.div_step) begin
            r_div_sh <= {r_div_sh[REQ_W-2:0], 1'b0};
            r_rem    <= w_rem_next;
        end
        if (i_cmd.round) begin
            r_need <= w_need;
        end
        if (i_cmd.k_init) begin
            r_k <= w_open_m1[SLOT_W-1:0];
        end else if (i_cmd.k_dec) begin
            r_k <= r_k - SLOT_W'(1);
        end
        if (i_cmd.rd_en) begin
            r_rd_addr <= w_rd_addr;
        end

        if (i_cmd.clear) begin
            r_res_status <= ST_CLEARED;
            r_res_block  <= '0;
            r_res_offset <= '0;
        end else if (i_cmd.set_empty) begin
            r_res_status <= ST_EMPTY;
            r_res_block  <= '0;
            r_res_offset <= '0;
        end else if (i_cmd.set_refused) begin
            r_res_status <= ST_REFUSED;
            r_res_block  <= '0;
            r_res_offset <= '0;
        end else if (i_cmd.open_blk) begin
            r_res_status <= ST_GRANTED;
            r_res_block  <= w_open_slot;
            r_res_offset <= '0;
        end else if (i_cmd.grant) begin
            r_res_status <= ST_GRANTED;
            r_res_block  <= r_rd_addr;
            r_res_offset <= w_fill;
        end

        if (i_cmd.load_out) begin
            r_out_status <= r_res_status;
            r_out_block  <= r_res_block;
            r_out_offset <= r_res_offset;
            r_out_total  <= r_total;
        end
    end

    // Block table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

endmodule

// File: hdl/arena_block_allocator_unit.sv
// ============================================================================
// arena_block_allocator_unit: region block allocator
// Rounds allocate requests to the granule, places them in the current block,
// searches older blocks newest first, or opens a new block.
// ============================================================================
// A release result goes straight to the finish state; an allocate result
// passes the remainder unit, rounding and the block checks, where a search
// reads and then checks up to MAX_BLOCKS blocks; either may wait for the
// previous result. One item is in work at a time; the next is taken in the
// cycle after the result is loaded. Reset clears all control state; the
// block table needs no clearing.
module arena_block_allocator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    aba_req_if.sink                        i_req,
    aba_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [aba_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [aba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import aba_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    aba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    aba_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_req_bytes    (i_req.request_bytes),
        .o_status       (o_res.status),
        .o_grant_block  (o_res.grant_block),
        .o_grant_offset (o_res.grant_offset),
        .o_total_bytes  (o_res.total_bytes)
    );

`ifndef SYNTHESIS
    // A new result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten before transfer");

    // A release result always reports an empty arena.
    a_clear_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |=> (o_res.status != ST_CLEARED) || (o_res.total_bytes == '0))
        else $error("release result with nonzero total");

    // Refusal happens only when every block slot is in use.
    a_refuse_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.set_refused |-> w_sts.full)
        else $error("request refused with free block slots");
`endif

endmodule
